### rtl/framed_joystick_command_parser_assert.svh
// Assertion macros for the framed joystick command parser checker.
`ifndef FRAMED_JOYSTICK_COMMAND_PARSER_ASSERT_SVH
`define FRAMED_JOYSTICK_COMMAND_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define FJCP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fjcp check failed: same-cycle rule");

// Next-cycle implication, disabled while reset is held.
`define FJCP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fjcp check failed: next-cycle rule");

`endif

### rtl/fjcp_pkg.sv
// Shared types and constants of the framed joystick command parser.
package fjcp_pkg;

  // Framing bytes
  localparam logic [7:0] START_BYTE = 8'd2;
  localparam logic [7:0] END_BYTE   = 8'd3;

  // Digit decoding and validity limit
  localparam logic [15:0] DIGIT_BASE = 16'd48;
  localparam logic [7:0]  BAD_LIMIT  = 8'd80;

  // Frame lengths and accumulator split
  localparam logic [7:0] COORD_LEN = 8'd6;
  localparam logic [7:0] CMD_LEN   = 8'd1;
  localparam logic [7:0] AXIS_LEN  = 8'd3;

  // Coordinate window: acc - 200 within +/-100 means acc within 100..300
  localparam logic [15:0] COORD_BIAS = 16'd200;
  localparam logic [15:0] COORD_LO   = 16'd100;
  localparam logic [15:0] COORD_HI   = 16'd300;

  // Command check: acc + 48 > 64 means acc > 16
  localparam logic [15:0] CMD_MIN_ACC = 16'd16;
  localparam logic [7:0]  CMD_OFFSET  = 8'd48;

  // Result kinds
  localparam logic KIND_COORD = 1'b0;
  localparam logic KIND_CMD   = 1'b1;

  typedef struct packed {
    logic              result_kind;
    logic signed [7:0] coord_x;
    logic signed [7:0] coord_y;
    logic        [7:0] command;
  } fjcp_res_t;

endpackage

### rtl/fjcp_if.sv
// Valid/ready channel interfaces for received bytes and parser results.
interface fjcp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fjcp_out_if;
  logic              valid;
  logic              ready;
  logic              result_kind;
  logic signed [7:0] coord_x;
  logic signed [7:0] coord_y;
  logic        [7:0] command;

  modport source (output valid, output result_kind, output coord_x, output coord_y,
                  output command, input ready);
  modport sink   (input valid, input result_kind, input coord_x, input coord_y,
                  input command, output ready);
endinterface

### rtl/framed_joystick_command_parser.sv
// A result word is offered from the result register after its end byte has
// left the input register. Throughput: one received byte per cycle while the
// output is taken; the 16-bit multiply-by-ten and add of the frame state sets
// the stage depth. A stalled output stops acceptance only once both the input
// and result registers are full. Reset (rst_n low, synchronous) closes any
// frame and clears flags, length, accumulators and both valid registers.
module framed_joystick_command_parser (
  input  logic       clk,
  input  logic       rst_n,
  fjcp_in_if.sink    in_ch,
  fjcp_out_if.source out_ch
);
  import fjcp_pkg::*;

  logic      space;
  logic      res_valid;
  fjcp_res_t res;
  fjcp_res_t out_res;
  logic      out_valid;
  logic      in_ready;

  // Frame state and evaluation
  fjcp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .in_byte   (in_ch.rx_byte),
    .space     (space),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register
  fjcp_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .load_res  (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  // Drive channel ports
  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid;
  assign out_ch.result_kind = out_res.result_kind;
  assign out_ch.coord_x     = out_res.coord_x;
  assign out_ch.coord_y     = out_res.coord_y;
  assign out_ch.command     = out_res.command;

endmodule

### rtl/fjcp_core.sv
// Input register, frame state and single-pass evaluation of one received word.
module fjcp_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_byte,
  input  logic                space,
  output logic                res_valid,
  output fjcp_pkg::fjcp_res_t res
);
  import fjcp_pkg::*;

  logic        full_r;
  logic [7:0]  byte_r;
  logic        recording_r, recording_nxt;
  logic        bad_r, bad_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [15:0] acc_x_r, acc_x_nxt;
  logic [15:0] acc_y_r, acc_y_nxt;

  logic        advance;
  logic [15:0] digit;
  logic [15:0] acc_sel;
  logic [15:0] acc_step;
  logic        coord_ok;
  logic        cmd_ok;
  logic        emit;
  logic [15:0] x_diff;
  logic [15:0] y_diff;

  // Move the held word into evaluation whenever the result side has room
  assign advance  = full_r && space;
  assign in_ready = !full_r || advance;

  // Decimal digit step: acc*10 + (byte - 48), wrapping at 16 bits
  assign digit    = {8'd0, byte_r} - DIGIT_BASE;
  assign acc_sel  = (len_r < AXIS_LEN) ? acc_x_r : acc_y_r;
  assign acc_step = (acc_sel << 3) + (acc_sel << 1) + digit;

  // Evaluate the current frame contents
  assign x_diff   = acc_x_r - COORD_BIAS;
  assign y_diff   = acc_y_r - COORD_BIAS;
  assign coord_ok = (len_r == COORD_LEN) &&
                    (acc_x_r >= COORD_LO) && (acc_x_r <= COORD_HI) &&
                    (acc_y_r >= COORD_LO) && (acc_y_r <= COORD_HI);
  assign cmd_ok   = (len_r == CMD_LEN) && (acc_x_r > CMD_MIN_ACC);
  assign emit     = (byte_r == END_BYTE) && !bad_r && (coord_ok || cmd_ok);

  assign res_valid = advance && emit;

  // Build the result word
  always_comb begin
    res = '0;
    if (coord_ok) begin
      res.result_kind = KIND_COORD;
      res.coord_x     = x_diff[7:0];
      res.coord_y     = y_diff[7:0];
    end else begin
      res.result_kind = KIND_CMD;
      res.command     = acc_x_r[7:0] + CMD_OFFSET;
    end
  end

  // Next frame state
  always_comb begin
    recording_nxt = recording_r;
    bad_nxt       = bad_r;
    len_nxt       = len_r;
    acc_x_nxt     = acc_x_r;
    acc_y_nxt     = acc_y_r;
    if (byte_r == START_BYTE) begin
      recording_nxt = 1'b1;
      bad_nxt       = 1'b0;
      len_nxt       = '0;
      acc_x_nxt     = '0;
      acc_y_nxt     = '0;
    end else if (byte_r == END_BYTE) begin
      recording_nxt = 1'b0;
    end else if (recording_r) begin
      if (len_r < COORD_LEN) begin
        if (len_r < AXIS_LEN) begin
          acc_x_nxt = acc_step;
        end else begin
          acc_y_nxt = acc_step;
        end
        if (byte_r > BAD_LIMIT) begin
          bad_nxt = 1'b1;
        end
      end
      len_nxt = len_r + 8'd1;
    end
  end

  // Hold the input word and advance the frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r      <= 1'b0;
      recording_r <= 1'b0;
      bad_r       <= 1'b0;
      len_r       <= '0;
      acc_x_r     <= '0;
      acc_y_r     <= '0;
    end else begin
      if (in_ready) begin
        full_r <= in_valid;
      end
      if (advance) begin
        recording_r <= recording_nxt;
        bad_r       <= bad_nxt;
        len_r       <= len_nxt;
        acc_x_r     <= acc_x_nxt;
        acc_y_r     <= acc_y_nxt;
      end
    end
  end

  // Capture the accepted word
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_byte;
    end
  end

endmodule

### rtl/fjcp_out_reg.sv
// Result register toward the output channel.
module fjcp_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  fjcp_pkg::fjcp_res_t load_res,
  output logic                space,
  output logic                out_valid,
  input  logic                out_ready,
  output fjcp_pkg::fjcp_res_t out_res
);
  import fjcp_pkg::*;

  logic      valid_r;
  fjcp_res_t res_r;

  // Room when empty or when the held word leaves this cycle
  assign space     = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  // Load result payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= load_res;
    end
  end

endmodule

### rtl/fjcp_checker.sv
// Port-level checks of the framed joystick command parser and their binding.
module fjcp_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_result_kind,
  input logic signed [7:0] out_coord_x,
  input logic signed [7:0] out_coord_y,
  input logic        [7:0] out_command
);
  import fjcp_pkg::*;
  `include "framed_joystick_command_parser_assert.svh"

  // Stalled result word stays offered
  `FJCP_ASSERT_NEXT(a_out_hold_valid, out_valid && !out_ready, out_valid)

  // Stalled result word keeps its payload
  `FJCP_ASSERT_NEXT(a_out_hold_data, out_valid && !out_ready, $stable(out_result_kind) && $stable(out_coord_x) && $stable(out_coord_y) && $stable(out_command))

  // Coordinate words stay within the window and carry no command
  `FJCP_ASSERT_NOW(a_coord_range, out_valid && (out_result_kind == KIND_COORD), (out_coord_x >= -8'sd100) && (out_coord_x <= 8'sd100) && (out_coord_y >= -8'sd100) && (out_coord_y <= 8'sd100) && (out_command == 8'd0))

  // Command words carry zero coordinates
  `FJCP_ASSERT_NOW(a_cmd_zero_coord, out_valid && (out_result_kind == KIND_CMD), (out_coord_x == 8'sd0) && (out_coord_y == 8'sd0))

endmodule

bind framed_joystick_command_parser fjcp_checker u_fjcp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_result_kind (out_ch.result_kind),
  .out_coord_x     (out_ch.coord_x),
  .out_coord_y     (out_ch.coord_y),
  .out_command     (out_ch.command)
);

### tb/sv/framed_joystick_command_parser_tb.sv
// Self-checking testbench for the framed joystick command parser.
module framed_joystick_command_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fjcp_pkg::*;

  localparam int PLAN_TARGET      = 1550;
  localparam int DIRECTED_COUNT   = 26;
  localparam int COORD_SPAN       = 100;
  localparam int CMD_THRESHOLD    = 64;
  localparam logic [15:0] DECIMAL = 16'd10;
  localparam int LONG_HOLD_AT     = 600;
  localparam int LONG_HOLD_CYCLES = 120;
  localparam int DRAIN_CYCLES     = 12;
  localparam int RUN_LIMIT_NS     = 3_000_000;

  // One received byte, with its expectation typed in where it is obvious
  typedef struct packed {
    logic [7:0] rx;
    logic       typed;
    logic       hit;
    fjcp_res_t  res;
  } plan_row_t;

  localparam plan_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    '{END_BYTE,   1'b1, 1'b0, '0},  // end byte straight out of reset
    '{START_BYTE, 1'b0, 1'b0, '0},
    '{8'h31, 1'b0, 1'b0, '0},       // "100" -> x at the low edge
    '{8'h30, 1'b0, 1'b0, '0},
    '{8'h30, 1'b0, 1'b0, '0},
    '{8'h33, 1'b0, 1'b0, '0},       // "300" -> y at the high edge
    '{8'h30, 1'b0, 1'b0, '0},
    '{8'h30, 1'b0, 1'b0, '0},
    '{END_BYTE, 1'b1, 1'b1, '{KIND_COORD, -8'sd100, 8'sd100, 8'h00}},
    '{END_BYTE, 1'b1, 1'b1, '{KIND_COORD, -8'sd100, 8'sd100, 8'h00}},  // same frame again
    '{8'h37, 1'b0, 1'b0, '0},       // data byte with no frame open
    '{START_BYTE, 1'b0, 1'b0, '0},
    '{8'h41, 1'b0, 1'b0, '0},
    '{END_BYTE, 1'b1, 1'b1, '{KIND_CMD, 8'sd0, 8'sd0, 8'h41}},
    '{START_BYTE, 1'b0, 1'b0, '0},
    '{8'h40, 1'b0, 1'b0, '0},       // sum lands exactly on the threshold
    '{END_BYTE, 1'b1, 1'b0, '0},
    '{START_BYTE, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},       // digit below zero wraps the accumulator
    '{END_BYTE, 1'b0, 1'b0, '0},
    '{START_BYTE, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},       // out-of-range byte spoils the frame
    '{END_BYTE, 1'b1, 1'b0, '0},
    '{START_BYTE, 1'b0, 1'b0, '0},
    '{8'h50, 1'b0, 1'b0, '0},       // highest byte still accepted as data
    '{END_BYTE, 1'b0, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst_n;

  fjcp_in_if  in_ch ();
  fjcp_out_if out_ch ();

  framed_joystick_command_parser uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Mirror of the parser's frame state
  logic        frame_open;
  logic        frame_bad;
  logic [7:0]  frame_len;
  logic [15:0] acc_x;
  logic [15:0] acc_y;

  plan_row_t rx_plan[$];
  fjcp_res_t pending_results[$];
  int        accepted_count = 0;
  int        n_errors = 0;
  bit        long_hold_done = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the frame state by one byte; return 1 when a result word is due
  function automatic bit parse_rx_byte(input logic [7:0] b, output fjcp_res_t res);
    logic [15:0]        digit;
    logic signed [15:0] x16;
    logic signed [15:0] y16;
    res = '0;
    if (b == START_BYTE) begin
      frame_open = 1'b1;
      frame_bad  = 1'b0;
      frame_len  = 8'd0;
      acc_x      = 16'd0;
      acc_y      = 16'd0;
      return 1'b0;
    end
    if (b == END_BYTE) begin
      frame_open = 1'b0;
      if (frame_bad) return 1'b0;
      if (frame_len == COORD_LEN) begin
        x16 = acc_x - COORD_BIAS;
        y16 = acc_y - COORD_BIAS;
        if (x16 < -COORD_SPAN || x16 > COORD_SPAN || y16 < -COORD_SPAN || y16 > COORD_SPAN)
          return 1'b0;
        res.result_kind = KIND_COORD;
        res.coord_x     = x16[7:0];
        res.coord_y     = y16[7:0];
        return 1'b1;
      end
      // Sum taken wide: an accumulator wrapped below zero still passes
      if (frame_len == CMD_LEN && 32'(acc_x) + 32'(CMD_OFFSET) > CMD_THRESHOLD) begin
        res.result_kind = KIND_CMD;
        res.command     = acc_x[7:0] + CMD_OFFSET;
        return 1'b1;
      end
      return 1'b0;
    end
    if (frame_open) begin
      if (frame_len < COORD_LEN) begin
        digit = {8'd0, b} - DIGIT_BASE;
        if (frame_len < AXIS_LEN) acc_x = acc_x * DECIMAL + digit;
        else acc_y = acc_y * DECIMAL + digit;
        if (b > BAD_LIMIT) frame_bad = 1'b1;
      end
      frame_len = frame_len + 8'd1;
    end
    return 1'b0;
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    plan_row_t row;
    row    = '0;
    row.rx = b;
    rx_plan.push_back(row);
  endfunction

  // Any byte that neither opens nor closes a frame
  function automatic logic [7:0] data_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == START_BYTE || b == END_BYTE);
    return b;
  endfunction

  // Stimulus, reset and sender
  initial begin
    logic [7:0] frame_bytes [6];
    fjcp_res_t  want;
    bit         hit;
    int         pick;
    int         v;
    int         len;
    int         gap;
    int         quiet_left;
    int         long_frames;

    in_ch.valid   = 1'b0;
    in_ch.rx_byte = 8'd0;
    rst_n         = 1'b0;
    frame_open    = 1'b0;
    frame_bad     = 1'b0;
    frame_len     = 8'd0;
    acc_x         = 16'd0;
    acc_y         = 16'd0;
    quiet_left    = 0;
    long_frames   = 0;

    foreach (DIRECTED_ROWS[i]) rx_plan.push_back(DIRECTED_ROWS[i]);

    // Mostly well-formed frames with random content, the rest noise
    while (rx_plan.size() < PLAN_TARGET) begin
      pick = $urandom_range(0, 99);
      if (long_frames < 2 && rx_plan.size() > 400 * (long_frames + 1)) begin
        // Length runs past 256 and wraps back to a coordinate or command length
        add_byte(START_BYTE);
        if (long_frames == 0) begin
          repeat (6) add_byte(8'(DIGIT_BASE + $urandom_range(0, 9)));
        end else begin
          add_byte(8'($urandom_range(49, 80)));
        end
        repeat (256) add_byte(data_byte());
        add_byte(END_BYTE);
        long_frames++;
      end else if (pick < 45) begin
        for (int k = 0; k < 2; k++) begin
          v = ($urandom_range(0, 9) < 7) ? $urandom_range(100, 300) : $urandom_range(0, 999);
          frame_bytes[3*k]     = 8'(DIGIT_BASE + v / 100);
          frame_bytes[3*k + 1] = 8'(DIGIT_BASE + (v / 10) % 10);
          frame_bytes[3*k + 2] = 8'(DIGIT_BASE + v % 10);
        end
        if ($urandom_range(0, 9) == 0) frame_bytes[$urandom_range(0, 5)] = data_byte();
        len = 6;
        pick = $urandom_range(0, 19);
        if (pick == 0) len = $urandom_range(0, 5);
        else if (pick == 1) len = $urandom_range(7, 9);
        add_byte(START_BYTE);
        for (int k = 0; k < len; k++) add_byte(k < 6 ? frame_bytes[k] : data_byte());
        add_byte(END_BYTE);
        if ($urandom_range(0, 9) == 0) add_byte(END_BYTE);
      end else if (pick < 75) begin
        add_byte(START_BYTE);
        add_byte(($urandom_range(0, 9) < 7) ? 8'($urandom_range(49, 80)) : data_byte());
        add_byte(END_BYTE);
      end else begin
        repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(0, 255)));
      end
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < rx_plan.size(); i++) begin
      if (i == DIRECTED_COUNT || i == rx_plan.size() / 2) begin
        // Hold the sender until every pending result has drained
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        @(negedge clk);
      end else begin
        if (quiet_left > 0) begin
          quiet_left--;
          gap = 0;
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 1) quiet_left = $urandom_range(50, 150);
          if (pick < 65) gap = 0;
          else if (pick < 92) gap = $urandom_range(1, 3);
          else gap = $urandom_range(4, 25);
        end
        if (gap > 0) begin
          in_ch.valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      in_ch.valid   <= 1'b1;
      in_ch.rx_byte <= rx_plan[i].rx;
      do @(posedge clk); while (!in_ch.ready);
      accepted_count++;
      hit = parse_rx_byte(rx_plan[i].rx, want);
      if (rx_plan[i].typed) begin
        hit  = rx_plan[i].hit;
        want = rx_plan[i].res;
      end
      if (hit) pending_results.push_back(want);
      @(negedge clk);
    end
    in_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0) $display("framed_joystick_command_parser_tb: done, clean");
    else $display("framed_joystick_command_parser_tb: done, errors");
    $finish;
  end

  // Result receiver: random stalls, calm stretches and one long hold-off
  initial begin
    int stall_left;
    int calm_left;
    int pick;
    out_ch.ready = 1'b0;
    stall_left   = 0;
    calm_left    = 0;
    forever begin
      @(negedge clk);
      if (!long_hold_done && accepted_count >= LONG_HOLD_AT) begin
        long_hold_done = 1'b1;
        stall_left     = LONG_HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (calm_left > 0) begin
          calm_left--;
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 2) calm_left = $urandom_range(50, 200);
          else if (pick < 14) stall_left = $urandom_range(1, 3);
          else if (pick < 16) stall_left = $urandom_range(8, 30);
        end
      end
    end
  end

  // Compare each taken result word with the oldest expectation
  always @(posedge clk) begin : check_results
    fjcp_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word: kind %0d x %0d y %0d command %0d",
               out_ch.result_kind, out_ch.coord_x, out_ch.coord_y, out_ch.command);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.result_kind !== want.result_kind) begin
          $error("result_kind: expected %0d, got %0d", want.result_kind, out_ch.result_kind);
          n_errors++;
        end
        if (out_ch.coord_x !== want.coord_x) begin
          $error("coord_x: expected %0d, got %0d", want.coord_x, out_ch.coord_x);
          n_errors++;
        end
        if (out_ch.coord_y !== want.coord_y) begin
          $error("coord_y: expected %0d, got %0d", want.coord_y, out_ch.coord_y);
          n_errors++;
        end
        if (out_ch.command !== want.command) begin
          $error("command: expected %0d, got %0d", want.command, out_ch.command);
          n_errors++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    #(RUN_LIMIT_NS);
    $display("framed_joystick_command_parser_tb: done, errors");
    $finish;
  end

endmodule
